/* hw/rtl/lap5_pkg.sv */
// package for the five-point laplacian stream
// widths, register indexes and the stencil helper; no dependencies
package lap5_pkg;

  localparam int unsigned SampleWidth  = 32;
  localparam int unsigned LapWidth     = 35;
  localparam int unsigned GridWBits    = 13;
  localparam int unsigned GridHBits    = 16;
  localparam int unsigned CfgIdxBits   = 1;
  localparam int unsigned MinGridDim   = 3;
  localparam int unsigned ResetGridDim = 4096;

  typedef enum logic [CfgIdxBits-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  typedef logic signed [SampleWidth-1:0] sample_t;
  typedef logic signed [LapWidth-1:0]    lap_t;

  // the four neighbours minus four times the centre, exact at 35 bits
  function automatic lap_t stencil(sample_t up, sample_t down, sample_t left,
                                   sample_t right, sample_t centre);
    lap_t sum_nb;
    lap_t four_c;
    sum_nb = lap_t'(up) + lap_t'(down) + lap_t'(left) + lap_t'(right);
    four_c = lap_t'(centre) <<< 2;
    return sum_nb - four_c;
  endfunction

endpackage

/* hw/rtl/laplacian_stencil_5pt_stream.sv */
// five-point laplacian over a raster stream of signed q16.16 grid values
// depends on lap5_pkg
//
// Grid values enter one per transfer in raster order and the block keeps the
// two previous rows in two line memories (row above, row two above) with
// registered reads. A new value can be accepted in every clock while results
// are taken. At the input transfer the line memories are read at the current
// column (centre, value above it) and at the next column (right neighbour)
// into stage two; when stage two retires the line memories are written back
// (centre shifts into the upper row, the new value into the row above) and,
// for an interior point, the stencil sum is loaded into the output register.
// A result is offered once the value below its centre point has passed stage
// two into the output register. A result waiting in the output register holds
// a stage two that carries a result, and a held stage two stalls the input.
// Border points give no result. last_point_o marks the final interior point
// of a grid. Width below 3 counts as 3 and above MAX_WIDTH as MAX_WIDTH;
// height below 3 counts as 3. A register write restarts the grid at row 0,
// column 0 and must only be made while the block is idle. The line memories
// need no clearing: every entry that enters a result belongs to the current grid.
module laplacian_stencil_5pt_stream #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [lap5_pkg::CfgIdxBits-1:0]      cfg_index_i,
  input  logic [lap5_pkg::GridHBits-1:0]       cfg_data_i,
  // input stream
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [lap5_pkg::SampleWidth-1:0] sample_i,
  // result stream
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lap5_pkg::LapWidth-1:0] laplacian_o,
  output logic                                 last_point_o
);

  localparam int unsigned AddrW  = $clog2(MAX_WIDTH);
  localparam int unsigned RstW   = (MAX_WIDTH < lap5_pkg::ResetGridDim) ?
                                   MAX_WIDTH : lap5_pkg::ResetGridDim;
  localparam int unsigned HW     = lap5_pkg::GridHBits;

  // effective grid geometry, kept as last and second-to-last column and last row
  logic [AddrW-1:0] col_last_q, col_last_d;
  logic [AddrW-1:0] col_pen_q, col_pen_d;
  logic [HW-1:0]    row_last_q, row_last_d;

  // raster position of the next sample
  logic [AddrW-1:0] col_q, col_d;
  logic [HW-1:0]    row_q, row_d;

  // line memories
  lap5_pkg::sample_t above_mem [MAX_WIDTH];
  lap5_pkg::sample_t two_above_mem [MAX_WIDTH];

  // stage two: memory read data plus the item's own fields
  logic              s2_valid_q;
  logic              s2_prod_q;
  logic              s2_last_q;
  logic [AddrW-1:0]  s2_col_q;
  lap5_pkg::sample_t s2_sample_q;
  lap5_pkg::sample_t mid_q;
  lap5_pkg::sample_t right_q;
  lap5_pkg::sample_t up_q;
  lap5_pkg::sample_t left_q;

  // stage three: output register
  logic              out_valid_q;
  lap5_pkg::lap_t    lap_q;
  logic              last_q;

  logic in_xfer;
  logic s2_adv;
  logic out_free;
  logic prod_now;
  logic last_now;
  logic [AddrW-1:0] right_addr;
  logic [lap5_pkg::GridWBits-1:0] cfg_w;
  logic [AddrW:0]   eff_w;
  logic [HW-1:0]    eff_h;

  // handshake: stage two moves on when it has no result or the output is free
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s2_adv     = s2_valid_q && (!s2_prod_q || out_free);
  assign in_stall_o = s2_valid_q && !s2_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // interior test and final-point test at the current position
  assign prod_now   = (row_q >= HW'(2)) && (col_q != '0) && (col_q < col_last_q);
  assign last_now   = (row_q == row_last_q) && (col_q == col_pen_q);
  assign right_addr = col_q + AddrW'(1);

  // clamp written width and height to the usable range
  always_comb begin
    cfg_w = cfg_data_i[lap5_pkg::GridWBits-1:0];
    if (32'(cfg_w) < lap5_pkg::MinGridDim) begin
      eff_w = (AddrW+1)'(lap5_pkg::MinGridDim);
    end else if (32'(cfg_w) > MAX_WIDTH) begin
      eff_w = (AddrW+1)'(MAX_WIDTH);
    end else begin
      eff_w = (AddrW+1)'(cfg_w);
    end
    if (32'(cfg_data_i) < lap5_pkg::MinGridDim) begin
      eff_h = HW'(lap5_pkg::MinGridDim);
    end else begin
      eff_h = cfg_data_i;
    end
  end

  // geometry registers and position counters
  always_comb begin
    col_last_d = col_last_q;
    col_pen_d  = col_pen_q;
    row_last_d = row_last_q;
    col_d      = col_q;
    row_d      = row_q;
    if (cfg_we_i) begin
      unique case (lap5_pkg::cfg_reg_e'(cfg_index_i))
        lap5_pkg::REG_GRID_WIDTH: begin
          col_last_d = AddrW'(eff_w - (AddrW+1)'(1));
          col_pen_d  = AddrW'(eff_w - (AddrW+1)'(2));
        end
        lap5_pkg::REG_GRID_HEIGHT: begin
          row_last_d = eff_h - HW'(1);
        end
        default: begin
        end
      endcase
      col_d = '0;
      row_d = '0;
    end else if (in_xfer) begin
      if (col_q == col_last_q) begin
        col_d = '0;
        // wrap to a new grid after the last row
        row_d = (row_q == row_last_q) ? '0 : row_q + HW'(1);
      end else begin
        col_d = col_q + AddrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_last_q <= AddrW'(RstW - 1);
      col_pen_q  <= AddrW'(RstW - 2);
      row_last_q <= HW'(lap5_pkg::ResetGridDim - 1);
      col_q      <= '0;
      row_q      <= '0;
    end else begin
      col_last_q <= col_last_d;
      col_pen_q  <= col_pen_d;
      row_last_q <= row_last_d;
      col_q      <= col_d;
      row_q      <= row_d;
    end
  end

  // line memories: read at the input transfer, write back when stage two
  // retires; a value written is read again no sooner than two items later,
  // so the read and the write of one edge never meet at one entry
  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      above_mem[s2_col_q] <= s2_sample_q;
    end
    if (in_xfer) begin
      mid_q   <= above_mem[col_q];
      right_q <= above_mem[right_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      two_above_mem[s2_col_q] <= mid_q;
    end
    if (in_xfer) begin
      up_q <= two_above_mem[col_q];
    end
  end

  // stage two control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_prod_q  <= 1'b0;
      s2_last_q  <= 1'b0;
      left_q     <= '0;
    end else begin
      if (in_xfer) begin
        s2_valid_q <= 1'b1;
        s2_prod_q  <= prod_now;
        s2_last_q  <= last_now;
      end else if (s2_adv) begin
        s2_valid_q <= 1'b0;
      end
      // left neighbour is the previous item's centre
      if (s2_adv) begin
        left_q <= mid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s2_col_q    <= col_q;
      s2_sample_q <= sample_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s2_adv && s2_prod_q) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s2_prod_q) begin
      lap_q  <= lap5_pkg::stencil(up_q, s2_sample_q, left_q, right_q, mid_q);
      last_q <= s2_last_q;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign laplacian_o  = lap_q;
  assign last_point_o = last_q;

endmodule
